// ----- sv/rmsfc_pkg.sv -----
// Shared types and constants for the register-mapped SPI front-end control block.
// Register map, frame constants and sequencer state type. No dependencies.
`timescale 1ns / 1ps

package rmsfc_pkg;

  localparam int AddrW  = 15;
  localparam int WordW  = 16;
  localparam int SelW   = 4;
  localparam int FrameW = 30;
  localparam int CntW   = 5;
  localparam int CfgIdxW = 2;

  localparam logic              OP_READ     = 1'b0;
  localparam logic              OP_WRITE    = 1'b1;

  localparam logic [13:0]       TUNER_CTRL  = 14'b01010000001000;
  localparam logic [10:0]       TUNER_MASK  = 11'h7FF;
  localparam logic [WordW-1:0]  BAD_READ    = 16'hEEEE;
  localparam logic [AddrW-1:0]  ADDR_ID_MAX = 15'h02;
  localparam logic [AddrW-1:0]  ADDR_GPIO   = 15'h10;
  localparam logic [AddrW-1:0]  ADDR_TUNER  = 15'h20;
  localparam logic [AddrW-1:0]  ADDR_DAC    = 15'h30;
  localparam logic [WordW-1:0]  TUNER_RESET = 16'h0200;

  localparam logic [SelW-1:0]   SEL_NONE    = 4'd0;
  localparam logic [SelW-1:0]   SEL_TUNER0  = 4'd1;
  localparam logic [SelW-1:0]   SEL_DAC0    = 4'd7;

  localparam logic [CntW-1:0]   BEATS_ONE   = 5'd1;
  localparam logic [CntW-1:0]   BEATS_TUNER = 5'd30;
  localparam logic [CntW-1:0]   BEATS_DAC   = 5'd16;

  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ID = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HW_VER    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FW_VER    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

endpackage

// ----- sv/register_mapped_spi_frontend_control_top.sv -----
// Top level of the register-mapped SPI front-end control block.
// Decodes register accesses and shifts tuner/DAC frames out bit by bit.
// Depends on rmsfc_pkg.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one register access per beat (opcode, reg_address, write_data).
//   out_* : result beats; a read, a GPIO write or a bad access gives one beat,
//           a tuner write 30 beats, a DAC write 16 beats, out_last on the final.
//   cfg_* : identification register writes, ready out of reset, index 0..2,
//           other indices ignored.
//   A single frame shift register with a beat counter delivers one result beat
//   per cycle while out_ready is high; the first beat shows in the cycle after
//   the access is taken.
//   in_ready is low from accept until the last beat is taken.
//   A stalled receiver holds the current beat; the sequencer waits with it.
//   Reset: tuner words to 0x0200, GPIO, DAC words and identification
//   registers to zero, no beat pending, in_ready and cfg_ready low.

module register_mapped_spi_frontend_control_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [rmsfc_pkg::WordW-1:0]   in_reg_address,
  input  logic [rmsfc_pkg::WordW-1:0]   in_write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rmsfc_pkg::SelW-1:0]    out_target_select,
  output logic                          out_serial_bit,
  output logic [rmsfc_pkg::WordW-1:0]   out_read_data,
  output logic                          out_access_error,
  output logic                          out_gpio_drive,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rmsfc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rmsfc_pkg::WordW-1:0]   cfg_data
);
  import rmsfc_pkg::*;

  state_t state_r, state_nxt;

  logic [WordW-1:0]  id_r [3];
  logic [WordW-1:0]  gpio_r;
  logic [WordW-1:0]  tuner_r [6];
  logic [WordW-1:0]  dac_r [2];

  logic [FrameW-1:0] shift_r;
  logic [CntW-1:0]   count_r;
  logic [SelW-1:0]   sel_r;
  logic [WordW-1:0]  rdata_r;
  logic              err_r;

  logic              in_acc, out_acc;
  logic [AddrW-1:0]  addr;
  logic              is_id, is_gpio, is_tuner, is_dac;
  logic [2:0]        t_idx;
  logic              d_idx;
  logic [WordW-1:0]  rd_val;
  logic [WordW-1:0]  t_frame, t_rev;
  logic [FrameW-1:0] frame_load;
  logic [CntW-1:0]   count_load;
  logic [SelW-1:0]   sel_load;
  logic [WordW-1:0]  rdata_load;
  logic              err_load;

  assign cfg_ready = rst_n;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // access decode
  always_comb begin
    addr     = in_reg_address[AddrW-1:0];
    is_id    = addr <= ADDR_ID_MAX;
    is_gpio  = addr == ADDR_GPIO;
    is_tuner = (addr >= ADDR_TUNER) && (addr < ADDR_TUNER + 15'd6);
    is_dac   = (addr == ADDR_DAC) || (addr == ADDR_DAC + 15'd1);
    t_idx    = addr[2:0];
    d_idx    = addr[0];

    rd_val = BAD_READ;
    if (is_id) begin
      rd_val = id_r[addr[1:0]];
    end else if (is_gpio) begin
      rd_val = gpio_r;
    end else if (is_tuner) begin
      rd_val = tuner_r[t_idx];
    end else if (is_dac) begin
      rd_val = dac_r[d_idx];
    end

    t_frame = {3'b000, in_write_data[10:0] & TUNER_MASK, 2'b10};
    for (int k = 0; k < WordW; k++) begin
      t_rev[WordW-1-k] = t_frame[k];
    end

    frame_load = '0;
    count_load = BEATS_ONE;
    sel_load   = SEL_NONE;
    rdata_load = '0;
    err_load   = 1'b0;
    if (in_opcode == OP_READ) begin
      rdata_load = rd_val;
      err_load   = !(is_id || is_gpio || is_tuner || is_dac);
    end else if (is_tuner) begin
      frame_load = {TUNER_CTRL, t_rev};
      count_load = BEATS_TUNER;
      sel_load   = SEL_TUNER0 + {1'b0, t_idx};
    end else if (is_dac) begin
      frame_load = {2'b00, in_write_data[7:0], 6'b000000, 14'b0};
      count_load = BEATS_DAC;
      sel_load   = SEL_DAC0 + {3'b000, d_idx};
    end else if (!is_gpio) begin
      err_load   = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_acc && (count_r == BEATS_ONE)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) id_r[i] <= '0;
      for (int i = 0; i < 6; i++) tuner_r[i] <= TUNER_RESET;
      dac_r[0] <= '0;
      dac_r[1] <= '0;
      gpio_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DEVICE_ID: id_r[0] <= cfg_data;
          CFG_HW_VER:    id_r[1] <= cfg_data;
          CFG_FW_VER:    id_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && (in_opcode == OP_WRITE)) begin
        if (is_gpio) begin
          gpio_r <= in_write_data;
        end else if (is_tuner) begin
          tuner_r[t_idx] <= in_write_data;
        end else if (is_dac) begin
          dac_r[d_idx] <= in_write_data;
        end
      end
    end
  end

  // frame shifter and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc) begin
      count_r <= count_load;
    end else if (out_acc) begin
      count_r <= count_r - BEATS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      shift_r <= frame_load;
      sel_r   <= sel_load;
      rdata_r <= rdata_load;
      err_r   <= err_load;
    end else if (out_acc) begin
      shift_r <= {shift_r[FrameW-2:0], 1'b0};
    end
  end

  assign out_valid         = state_r == ST_SEND;
  assign out_target_select = sel_r;
  assign out_serial_bit    = shift_r[FrameW-1];
  assign out_read_data     = rdata_r;
  assign out_access_error  = err_r;
  assign out_gpio_drive    = gpio_r[0];
  assign out_last          = count_r == BEATS_ONE;

endmodule
